/* sv/fir128_pkg.sv */
// ----------------------------------------------------------------------------
// fir128_pkg
// Shared types and constants for the 128-tap direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir128_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int COEF_IN_W = 16;
    localparam int INDEX_W   = 7;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_HOLD
    } t_state;

    // tag that travels with each tap read through the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

/* sv/fir128_ram.sv */
// ----------------------------------------------------------------------------
// fir128_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fir128_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fir128_mac.sv */
// ----------------------------------------------------------------------------
// fir128_mac
// Multiply-accumulate pipeline: product register, then wrapping accumulator.
// ----------------------------------------------------------------------------
module fir128_mac
    import fir128_pkg::*;
#(
    parameter int COEF_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mac_ctl                     i_ctl,
    input  logic [SAMPLE_W-1:0]          i_sample,
    input  logic signed [COEF_WIDTH-1:0] i_coef,
    output logic                         o_res_vld,
    output logic [SAMPLE_W-1:0]          o_result
);

    t_mac_ctl            r_c1;
    t_mac_ctl            r_c2;
    logic [SAMPLE_W-1:0] r_prod;
    logic [SAMPLE_W-1:0] r_acc;
    logic                r_res_vld;
    logic [SAMPLE_W-1:0] coef_ext;
    logic [SAMPLE_W-1:0] prod;

    assign coef_ext = SAMPLE_W'(i_coef);
    // low word of the product is the same for signed and unsigned operands
    assign prod     = i_sample * coef_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1      <= '0;
            r_c2      <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_c1      <= i_ctl;
            r_c2      <= r_c1;
            r_res_vld <= r_c2.vld && r_c2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (r_c2.vld) begin
            r_acc <= r_c2.first ? r_prod : r_acc + r_prod;
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_result  = r_acc;

endmodule

/* sv/fir_filter_128_tap_top.sv */
// ----------------------------------------------------------------------------
// fir_filter_128_tap_top
// Direct-form FIR filter over a RAM delay line and a loadable coefficient RAM.
// ----------------------------------------------------------------------------
// After reset the block zeroes every entry of both RAMs and takes no request.
// A coefficient-write request gives no result; an index at or beyond TAPS is
// dropped. A filter request writes the sample into a circular delay line and
// then reads one tap per cycle from each RAM into a single multiply-accumulate
// unit; no new request is taken until its result has been loaded into the
// output register. Products and sums wrap to 32 bits.
module fir_filter_128_tap_top
    import fir128_pkg::*;
#(
    parameter int TAPS       = 128,
    parameter int COEF_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    input  logic [INDEX_W-1:0]          i_coef_index,
    input  logic signed [COEF_IN_W-1:0] i_coef_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_filtered_sample
);

    localparam int AW = $clog2(TAPS);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_tap, n_tap;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [AW-1:0]       r_head, n_head;
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_data;

    logic                d_we;
    logic [AW-1:0]       d_waddr;
    logic [SAMPLE_W-1:0] d_wdata;
    logic [SAMPLE_W-1:0] d_rdata;
    logic                c_we;
    logic [AW-1:0]       c_waddr;
    logic [COEF_WIDTH-1:0] c_wdata;
    logic [COEF_WIDTH-1:0] c_rdata;

    t_mac_ctl            mac_ctl;
    logic                res_vld;
    logic [SAMPLE_W-1:0] result;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic [AW-1:0]       head_new;
    logic [31:0]         idx_ext;
    logic                idx_ok;
    logic [31:0]         coef_ext;
    logic                tap_last;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;
    assign head_new = (r_head == '0) ? AW'(TAPS - 1) : r_head - 1'b1;
    assign idx_ext  = 32'(i_coef_index);
    assign idx_ok   = idx_ext < 32'(TAPS);
    assign coef_ext = 32'(i_coef_value);
    assign tap_last = r_tap == AW'(TAPS - 1);

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        n_rd_addr = r_rd_addr;
        n_head    = r_head;
        o_in_ready = 1'b0;
        load_out  = 1'b0;
        d_we      = 1'b0;
        d_waddr   = head_new;
        d_wdata   = i_sample_in;
        c_we      = 1'b0;
        c_waddr   = idx_ext[AW-1:0];
        c_wdata   = coef_ext[COEF_WIDTH-1:0];
        mac_ctl   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                d_we    = 1'b1;
                d_waddr = r_tap;
                d_wdata = '0;
                c_we    = 1'b1;
                c_waddr = r_tap;
                c_wdata = '0;
                n_tap   = r_tap + 1'b1;
                if (tap_last) begin
                    n_tap   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation == OP_COEF) begin
                        c_we = idx_ok;
                    end else begin
                        d_we      = 1'b1;
                        n_head    = head_new;
                        n_rd_addr = head_new;
                        n_tap     = '0;
                        n_state   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                mac_ctl.vld   = 1'b1;
                mac_ctl.first = r_tap == '0;
                mac_ctl.last  = tap_last;
                n_tap     = r_tap + 1'b1;
                n_rd_addr = (r_rd_addr == AW'(TAPS - 1)) ? '0 : r_rd_addr + 1'b1;
                if (tap_last) begin
                    n_tap   = '0;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res_vld) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_tap   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_tap     <= '0;
            r_rd_addr <= '0;
            r_head    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tap     <= n_tap;
            r_rd_addr <= n_rd_addr;
            r_head    <= n_head;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= result;
        end
    end

    fir128_ram #(
        .DEPTH (TAPS),
        .WIDTH (SAMPLE_W)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (d_rdata)
    );

    fir128_ram #(
        .DEPTH (TAPS),
        .WIDTH (COEF_WIDTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_tap),
        .o_rdata (c_rdata)
    );

    fir128_mac #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_sample  (d_rdata),
        .i_coef    (c_rdata),
        .o_res_vld (res_vld),
        .o_result  (result)
    );

    assign o_out_valid       = r_out_vld;
    assign o_filtered_sample = r_out_data;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !o_in_ready)
        else $error("request taken during RAM clear");

    a_res_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> r_state == ST_WAIT)
        else $error("MAC result outside of wait state");

    a_filter_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == OP_FILTER |=> r_state == ST_RUN && r_tap == '0)
        else $error("filter request did not start tap sweep");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("output register overwritten");

endmodule

/* tb/fir_filter_128_tap_top_tb.sv */
// ----------------------------------------------------------------------------
// fir_filter_128_tap_top_tb
// Self-checking bench for the 128-tap FIR filter with loadable coefficients.
// ----------------------------------------------------------------------------
// Filter and coefficient-write requests go in over the valid/ready channel.
// A cycle-free model of the delay line and the coefficient store predicts
// each filtered sample, which is checked in order against the output channel.
// Directed reset-state and extreme tests come first, then the default table,
// then random traffic under changing idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module fir_filter_128_tap_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fir128_pkg::*;

    localparam int TAP_COUNT   = 128;
    localparam int COEF_W      = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_operation;
    logic signed [SAMPLE_W-1:0]  i_sample_in;
    logic [INDEX_W-1:0]          i_coef_index;
    logic signed [COEF_IN_W-1:0] i_coef_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_filtered_sample;

    // model state
    logic [SAMPLE_W-1:0]      tap_history [TAP_COUNT];
    logic signed [COEF_W-1:0] coef_table  [TAP_COUNT];
    logic [SAMPLE_W-1:0]      pending_outputs [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_count     = 0;
    int          filter_count   = 0;
    int          coef_count     = 0;
    int          result_count   = 0;
    int unsigned cycle_count    = 0;

    fir_filter_128_tap_top #(
        .TAPS       (TAP_COUNT),
        .COEF_WIDTH (COEF_W)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_sample_in       (i_sample_in),
        .i_coef_index      (i_coef_index),
        .i_coef_value      (i_coef_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic note_failure(input string what, input logic [SAMPLE_W-1:0] want,
                                input logic [SAMPLE_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Update the model with one accepted request; queue the filtered sample.
    task automatic track_request(input logic op, input logic [SAMPLE_W-1:0] sample,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [COEF_IN_W-1:0] value);
        logic [SAMPLE_W-1:0] acc;
        logic [SAMPLE_W-1:0] coef_ext;
        if (op == OP_COEF) begin
            coef_count++;
            if (int'(idx) < TAP_COUNT)
                coef_table[idx] = value[COEF_W-1:0];
        end else begin
            filter_count++;
            for (int i = TAP_COUNT - 1; i > 0; i--)
                tap_history[i] = tap_history[i-1];
            tap_history[0] = sample;
            acc = '0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                coef_ext = {{(SAMPLE_W-COEF_W){coef_table[i][COEF_W-1]}}, coef_table[i]};
                acc = acc + tap_history[i] * coef_ext;  // low 32 bits only
            end
            pending_outputs.push_back(acc);
        end
    endtask

    // Present one request, optionally after an idle gap, and wait for accept.
    task automatic send_request(input logic op, input logic [SAMPLE_W-1:0] sample,
                                input logic [INDEX_W-1:0] idx,
                                input logic [COEF_IN_W-1:0] value);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_sample_in  <= sample;
        i_coef_index <= idx;
        i_coef_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        track_request(op, sample, idx, value);
    endtask

    // Output side: check each accepted result, then pick next ready.
    initial begin
        logic [SAMPLE_W-1:0] want;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (pending_outputs.size() == 0) begin
                    note_failure("result with no request pending", 'x, o_filtered_sample);
                end else begin
                    want = pending_outputs.pop_front();
                    if (o_filtered_sample !== want)
                        note_failure("filtered_sample mismatch", want, o_filtered_sample);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_outputs.size());
        $display("** fir_filter_128_tap_top: FAILED **");
        $finish;
    end

    // All-zero coefficients after reset: any sample filters to zero.
    task automatic test_reset_state();
        send_request(OP_FILTER, 32'h7FFF_FFFF, '0, '0);
        send_request(OP_FILTER, 32'h8000_0000, '1, '1);
    endtask

    // Extreme coefficients and samples; writes between filters must not
    // disturb the delay line, and products/sums wrap.
    task automatic test_extremes();
        send_request(OP_COEF,   32'h0, 7'd0, 16'sd1);
        send_request(OP_FILTER, 32'h7FFF_FFFF, 7'd0, 16'h0);
        send_request(OP_COEF,   32'hFFFF_FFFF, 7'd127, 16'h8000);
        send_request(OP_COEF,   32'h0, 7'd1, 16'h7FFF);
        send_request(OP_COEF,   32'h0, 7'd0, 16'hFFFF);
        send_request(OP_COEF,   32'h0, 7'h55, 16'h5555);
        send_request(OP_COEF,   32'h0, 7'h2A, 16'hAAAA);
        send_request(OP_FILTER, 32'h8000_0000, 7'h7F, 16'hFFFF);
        send_request(OP_FILTER, 32'hFFFF_FFFF, 7'h00, 16'h0000);
        send_request(OP_FILTER, 32'h0000_0001, 7'h55, 16'h5555);
        send_request(OP_FILTER, 32'h7FFF_FFFF, 7'h2A, 16'hAAAA);
        send_request(OP_FILTER, 32'h0000_0000, 7'h00, 16'h0000);
        send_request(OP_FILTER, 32'h5555_5555, 7'h00, 16'h0000);
        send_request(OP_FILTER, 32'hAAAA_AAAA, 7'h00, 16'h0000);
    endtask

    // Load the default low-magnitude table, then run a short impulse.
    task automatic test_default_table();
        logic [COEF_IN_W-1:0] c;
        for (int i = 0; i < TAP_COUNT; i++) begin
            case (i % 8)
                0:       c = 16'sd10;
                1:       c = 16'sd11;
                2:       c = 16'sd8;
                3:       c = 16'sd3;
                4:       c = -16'sd3;
                5:       c = -16'sd8;
                6:       c = -16'sd11;
                default: c = -16'sd10;
            endcase
            send_request(OP_COEF, $urandom, INDEX_W'(i), c);
        end
        send_request(OP_FILTER, 32'h1, '0, '0);
        repeat (7) send_request(OP_FILTER, 32'h0, '0, '0);
    endtask

    // Mixed traffic, mostly filtering, with occasional coefficient updates.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        logic [SAMPLE_W-1:0]  s;
        logic [COEF_IN_W-1:0] c;
        int                   pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 20) begin
                if (pick < 60)
                    c = COEF_IN_W'(int'($urandom_range(22)) - 11);
                else if (pick < 85)
                    c = COEF_IN_W'($urandom);
                else
                    case ($urandom_range(3))
                        0:       c = 16'h7FFF;
                        1:       c = 16'h8000;
                        2:       c = 16'h0000;
                        default: c = 16'hFFFF;
                    endcase
                send_request(OP_COEF, $urandom, INDEX_W'($urandom), c);
            end else begin
                if (pick < 50)
                    s = $urandom;
                else if (pick < 80)
                    s = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
                else
                    case ($urandom_range(4))
                        0:       s = 32'h8000_0000;
                        1:       s = 32'h7FFF_FFFF;
                        2:       s = 32'h0000_0000;
                        3:       s = 32'hFFFF_FFFF;
                        default: s = 32'h0000_0001;
                    endcase
                send_request(OP_FILTER, s, INDEX_W'($urandom), COEF_IN_W'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TAP_COUNT; i++) begin
            tap_history[i] = '0;
            coef_table[i]  = '0;
        end
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_FILTER;
        i_sample_in  <= '0;
        i_coef_index <= '0;
        i_coef_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_default_table();
        test_random_traffic(375, 0, 0);
        test_random_traffic(375, 53, 0);
        test_random_traffic(375, 0, 53);
        test_random_traffic(375, 27, 27);
        i_in_valid <= 1'b0;

        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (TAP_COUNT + 8) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            fail_count += pending_outputs.size();
            $display("%0d results never arrived", pending_outputs.size());
        end

        $display("Covered %0d filter requests and %0d coefficient writes; %0d results checked",
                 filter_count, coef_count, result_count);
        $display("in %0d cycles under idle/stall mixes, %0d failures",
                 cycle_count, fail_count);
        if (fail_count == 0)
            $display("** fir_filter_128_tap_top: PASSED **");
        else
            $display("** fir_filter_128_tap_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
sv/fir128_pkg.sv
sv/fir128_ram.sv
sv/fir128_mac.sv
sv/fir_filter_128_tap_top.sv
tb/fir_filter_128_tap_top_tb.sv
